/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is applied.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define AADF_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AADF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define AADF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aadf_pkg.sv */
// ---------------------------------------------------------------------------
// aadf_pkg
// Shared constants, opcodes and divider handshake types for the ADC
// averaging decimator.
// ---------------------------------------------------------------------------
package aadf_pkg;

  localparam int FIFO_DEPTH  = 256;
  localparam int SAMPLE_BITS = 12;

  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = 8;
  localparam int FULL_COUNT = 8;
  localparam int AVG_SHIFT  = 3;
  localparam int SUM_W      = SAMPLE_BITS + AVG_SHIFT;
  localparam int CNT_W      = 4;
  localparam int DIVISOR_W  = 3;

  // Divider works four quotient bits per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIVIDEND_W = ((SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS) * DIV_RADIX_BITS;
  localparam int DIV_STEPS  = DIVIDEND_W / DIV_RADIX_BITS;
  localparam int DIV_STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 1 + SAMPLE_BITS + 1 + SAMPLE_BITS + FILL_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;
  localparam logic [OP_W-1:0] OP_OVF_CLR = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/aadf_ram.sv */
// ---------------------------------------------------------------------------
// aadf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ---------------------------------------------------------------------------
module aadf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/aadf_div.sv */
// ---------------------------------------------------------------------------
// aadf_div
// Iterative restoring divider for sum / count, four quotient bits per
// cycle. Raises done for one cycle when the quotient is ready.
// ---------------------------------------------------------------------------
module aadf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  aadf_pkg::div_req_t req,
  output aadf_pkg::div_rsp_t rsp
);

  localparam int REM_W = aadf_pkg::DIVISOR_W + 1;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [aadf_pkg::DIV_STEP_W-1:0]   step_r, step_nxt;
  logic [aadf_pkg::DIVIDEND_W-1:0]   quo_r, quo_nxt;
  logic [REM_W-1:0]                  rem_r, rem_nxt;
  logic [aadf_pkg::DIVISOR_W-1:0]    dvsr_r;
  logic [aadf_pkg::DIVIDEND_W-1:0]   quo_step;
  logic [REM_W-1:0]                  rem_step;

  // Four dependent shift-compare-subtract steps on a narrow remainder
  always_comb begin
    quo_step = quo_r;
    rem_step = rem_r;
    for (int i = 0; i < aadf_pkg::DIV_RADIX_BITS; i++) begin
      rem_step = {rem_step[REM_W-2:0], quo_step[aadf_pkg::DIVIDEND_W-1]};
      quo_step = {quo_step[aadf_pkg::DIVIDEND_W-2:0], 1'b0};
      if (rem_step >= {1'b0, dvsr_r}) begin
        rem_step    = rem_step - {1'b0, dvsr_r};
        quo_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = aadf_pkg::DIVIDEND_W'(req.dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = quo_step;
      rem_nxt  = rem_step;
      step_nxt = step_r + 1'b1;
      if (step_r == aadf_pkg::DIV_STEP_W'(aadf_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvsr_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[aadf_pkg::SAMPLE_BITS-1:0];

endmodule

/* rtl/adc_average_decimator_fifo.sv */
// ---------------------------------------------------------------------------
// adc_average_decimator_fifo
// Boxcar averaging decimator for ADC conversions with a ring FIFO of
// averages held in a synchronous RAM.
// ---------------------------------------------------------------------------
// An accepted transaction passes S_EXEC and then S_OUT, where the result
//   loads into the output register, for pop, flush, overflow clear and plain
//   samples; an emit of a full or empty period adds S_PUSH, and an emit that
//   goes through the divider waits in S_DIV before S_PUSH. One transaction
//   is in flight at a time: a new one is taken only in S_IDLE.
// Reset: synchronous, active low; clears accumulator, pointers, overflow
//   flag and handshake state. FIFO RAM contents are not cleared.
module adc_average_decimator_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: sample [11:0], period_due [12], zero padding [15:13]
  input  logic [aadf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: op [1:0]
  input  logic [aadf_pkg::OP_W-1:0]        in_tuser,
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: average_valid [0], average_value [12:1], pop_valid [13],
  //        pop_value [25:14], fill_level [33:26], overflow_flag [34],
  //        zero padding [39:35]
  output logic [aadf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `include "assert_macros.svh"

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int SB = aadf_pkg::SAMPLE_BITS;
  localparam int PW = aadf_pkg::PTR_W;

  logic [2:0]                      state_r, state_nxt;
  logic [aadf_pkg::OP_W-1:0]       op_r;
  logic [SB-1:0]                   smp_r;
  logic                            due_r;
  logic [aadf_pkg::SUM_W-1:0]      acc_sum_r, acc_sum_nxt;
  logic [aadf_pkg::CNT_W-1:0]      acc_cnt_r, acc_cnt_nxt;
  logic [PW-1:0]                   wp_r, wp_nxt;
  logic [PW-1:0]                   rp_r, rp_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            avg_v_r, avg_v_nxt;
  logic [SB-1:0]                   avg_r, avg_nxt;
  logic                            pop_v_r, pop_v_nxt;
  logic                            ovf_hold_r, ovf_hold_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [aadf_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                            in_acc;
  logic                            out_load;
  logic [aadf_pkg::SUM_W-1:0]      sum_acc;
  logic [aadf_pkg::CNT_W-1:0]      cnt_acc;
  logic [PW-1:0]                   wp_inc;
  logic [PW-1:0]                   rp_inc;
  logic [PW:0]                     fill_wide;
  logic [aadf_pkg::FILL_W-1:0]     fill_now;

  logic                            ram_we;
  logic                            ram_re;
  logic [SB-1:0]                   ram_rdata;

  aadf_pkg::div_req_t              div_req;
  aadf_pkg::div_rsp_t              div_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // The output register frees its slot when the current result is taken
  assign out_load = !out_tvalid_r || out_tready;

  // Accumulate: ignore samples once a full period is held
  always_comb begin
    if (acc_cnt_r < aadf_pkg::CNT_W'(aadf_pkg::FULL_COUNT)) begin
      sum_acc = acc_sum_r + aadf_pkg::SUM_W'(smp_r);
      cnt_acc = acc_cnt_r + 1'b1;
    end else begin
      sum_acc = acc_sum_r;
      cnt_acc = acc_cnt_r;
    end
  end

  // Ring pointer advance, valid for any depth
  assign wp_inc = (wp_r == PW'(aadf_pkg::FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PW'(aadf_pkg::FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;

  // Fill level: (write minus read) modulo depth
  assign fill_wide = (wp_r >= rp_r) ? ({1'b0, wp_r} - {1'b0, rp_r})
                   : ({1'b0, wp_r} + (PW + 1)'(aadf_pkg::FIFO_DEPTH) - {1'b0, rp_r});
  assign fill_now  = aadf_pkg::FILL_W'(fill_wide);

  always_comb begin
    state_nxt      = state_r;
    acc_sum_nxt    = acc_sum_r;
    acc_cnt_nxt    = acc_cnt_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    ovf_nxt        = ovf_r;
    avg_v_nxt      = avg_v_r;
    avg_nxt        = avg_r;
    pop_v_nxt      = pop_v_r;
    ovf_hold_nxt   = ovf_hold_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_acc;
    div_req.divisor  = cnt_acc[aadf_pkg::DIVISOR_W-1:0];

    // Drop the shown result once it has been taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          avg_v_nxt = 1'b0;
          avg_nxt   = '0;
          pop_v_nxt = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ovf_hold_nxt = ovf_r;
        case (op_r)
          aadf_pkg::OP_SAMPLE: begin
            if (due_r) begin
              // Emit: clear the accumulator, pick the cheap path if possible
              acc_sum_nxt = '0;
              acc_cnt_nxt = '0;
              if (cnt_acc == aadf_pkg::CNT_W'(aadf_pkg::FULL_COUNT)) begin
                avg_nxt   = SB'(sum_acc >> aadf_pkg::AVG_SHIFT);
                state_nxt = S_PUSH;
              end else if (cnt_acc == '0) begin
                avg_nxt   = '0;
                state_nxt = S_PUSH;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end else begin
              acc_sum_nxt = sum_acc;
              acc_cnt_nxt = cnt_acc;
              state_nxt   = S_OUT;
            end
          end
          aadf_pkg::OP_POP: begin
            // Read the head entry; data lands in the RAM output register
            if (wp_r != rp_r) begin
              ram_re    = 1'b1;
              rp_nxt    = rp_inc;
              pop_v_nxt = 1'b1;
            end
            state_nxt = S_OUT;
          end
          aadf_pkg::OP_FLUSH: begin
            wp_nxt    = '0;
            rp_nxt    = '0;
            state_nxt = S_OUT;
          end
          aadf_pkg::OP_OVF_CLR: begin
            ovf_nxt   = 1'b0;
            state_nxt = S_OUT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      S_DIV: begin
        if (div_rsp.done) begin
          avg_nxt   = div_rsp.quotient;
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        // Write the average at the tail; meeting the read pointer is overflow
        ram_we    = 1'b1;
        wp_nxt    = wp_inc;
        avg_v_nxt = 1'b1;
        if (wp_inc == rp_r) begin
          ovf_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // Hold until the output register is free, then present the result
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {
            {aadf_pkg::OUT_PAD_W{1'b0}},
            (op_r == aadf_pkg::OP_OVF_CLR) ? ovf_hold_r : ovf_r,
            fill_now,
            pop_v_r ? ram_rdata : {SB{1'b0}},
            pop_v_r,
            avg_r,
            avg_v_r
          };
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acc_sum_r    <= '0;
      acc_cnt_r    <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_sum_r    <= acc_sum_nxt;
      acc_cnt_r    <= acc_cnt_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      ovf_r        <= ovf_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      smp_r <= in_tdata[SB-1:0];
      due_r <= in_tdata[SB];
    end
    avg_v_r     <= avg_v_nxt;
    avg_r       <= avg_nxt;
    pop_v_r     <= pop_v_nxt;
    ovf_hold_r  <= ovf_hold_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // One item in flight at a time, so a write and a read of the same entry
  // never overlap and the RAM needs no forwarding.
  aadf_ram #(
    .WIDTH (SB),
    .DEPTH (aadf_pkg::FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (avg_r),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  aadf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `AADF_ASSERT_HOLD(a_cnt_bound, clk, rst_n, acc_cnt_r <= aadf_pkg::CNT_W'(aadf_pkg::FULL_COUNT), "accumulator count above a full period")
  `AADF_ASSERT_IMPL(a_ram_excl, clk, rst_n, ram_we, !ram_re && state_r == S_PUSH, "RAM write outside push or alongside a read")
  `AADF_ASSERT_NEXT(a_acc_exec, clk, rst_n, in_tvalid && in_tready, state_r == S_EXEC, "accepted transaction did not start execution")
  `AADF_ASSERT_IMPL(a_div_state, clk, rst_n, div_rsp.done, state_r == S_DIV, "divider finished while sequencer not waiting")

endmodule
